@@ sv/tcp_pkg.sv @@
// Shared types, codes and constants for the 8-bit timer/counter with PWM.
// No dependencies; every other file of the block imports this package.
package tcp_pkg;

    // Counter width and derived limits.
    localparam int COUNT_WIDTH = 8;
    localparam logic [COUNT_WIDTH-1:0] TOP_COUNT = {COUNT_WIDTH{1'b1}};

    // External field widths.
    localparam int VALUE_W = 8;
    localparam int PRESCALE_W = 10;
    localparam int DIV_W = PRESCALE_W + 1;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    typedef enum logic [1:0] {
        WAVE_NORMAL    = 2'd0,
        WAVE_CTC       = 2'd1,
        WAVE_FAST_PWM  = 2'd2,
        WAVE_PHASE_PWM = 2'd3
    } wave_mode_t;

    // Clock select codes.
    localparam logic [2:0] CS_STOP    = 3'd0;
    localparam logic [2:0] CS_DIV1    = 3'd1;
    localparam logic [2:0] CS_DIV8    = 3'd2;
    localparam logic [2:0] CS_DIV64   = 3'd3;
    localparam logic [2:0] CS_DIV256  = 3'd4;
    localparam logic [2:0] CS_DIV1024 = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_WAVE_MODE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLOCK_SELECT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMPARE_VALUE = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERT_OUTPUT = 2'd3;

    // Input item kinds.
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    typedef struct packed {
        wave_mode_t         wave_mode;
        logic [2:0]         clock_select;
        logic [VALUE_W-1:0] compare_value;
        logic               invert_output;
    } tcp_cfg_t;

    typedef struct packed {
        logic               wave_pin;
        logic               compare_event;
        logic               overflow_event;
        logic [VALUE_W-1:0] count_now;
    } tcp_result_t;

    // Prescaler divisor for a clock select code; zero means stopped.
    function automatic logic [DIV_W-1:0] divisor_of(input logic [2:0] sel);
        logic [DIV_W-1:0] div;
        unique case (sel)
            CS_DIV1:    div = DIV_W'(1);
            CS_DIV8:    div = DIV_W'(8);
            CS_DIV64:   div = DIV_W'(64);
            CS_DIV256:  div = DIV_W'(256);
            CS_DIV1024: div = DIV_W'(1024);
            default:    div = '0;
        endcase
        return div;
    endfunction

endpackage

@@ sv/timer_counter_pwm_8bit_core.sv @@
// Flow: an accepted item waits in the input register, and its result then waits in
// the result register. Throughput: one item per cycle while the sink keeps m_tready
// high, set by the single step of the timer logic between the two registers.
// Reset: aresetn is synchronous and active low; it clears the configuration,
// the prescaler, the counter, the count direction, the waveform level and both
// valid flags. Depends on tcp_pkg, tcp_cfg_regs and tcp_timer_step.
module timer_counter_pwm_8bit_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input item stream.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tcp_pkg::S_TDATA_W-1:0]      s_tdata,   // [7:0] load_value
    input  logic                               s_tuser,   // [0] action
    // Result item stream.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] count_now, [8] overflow_event, [9] compare_event, [10] wave_pin,
    // [15:11] zero
    output logic [tcp_pkg::M_TDATA_W-1:0]      m_tdata,
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tcp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tcp_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tcp_pkg::*;

    tcp_cfg_t    cfg;
    tcp_result_t step_result;

    // Input register: holds one accepted item until the timer logic takes it.
    logic               in_valid_reg, in_valid_next;
    logic               in_action_reg;
    logic [VALUE_W-1:0] in_load_reg;

    // Result register: holds one finished item until the sink takes it.
    logic               out_valid_reg, out_valid_next;
    tcp_result_t        out_result_reg;

    logic advance;
    logic step;
    logic in_fire;

    // The result register can take a new item when it is empty or being drained,
    // so a full pipeline still moves one item per cycle while the sink keeps taking results.
    assign advance = !out_valid_reg || m_tready;
    assign step = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign in_fire = s_tvalid && s_tready;

    assign in_valid_next = in_fire ? 1'b1 : (step ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    tcp_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The timer state advances only when an item leaves the input register.
    tcp_timer_step u_timer_step (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .step       (step),
        .action     (in_action_reg),
        .load_value (in_load_reg),
        .result     (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            in_action_reg <= s_tuser;
            in_load_reg <= s_tdata[VALUE_W-1:0];
        end
        if (step) begin
            out_result_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = M_TDATA_W'(out_result_reg);

`ifndef NO_ASSERTIONS
    // A load item never reports an overflow or a compare match.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && in_action_reg == ACT_LOAD) |=>
            (!out_result_reg.overflow_event && !out_result_reg.compare_event))
        else $error("load item reported a timer event");

    // Outside the PWM modes the waveform pin stays low.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && !cfg.wave_mode[1]) |=> !out_result_reg.wave_pin)
        else $error("waveform pin driven in a non-PWM mode");

    // A result waits in the output register until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("pending result lost or changed");
`endif

endmodule

@@ sv/tcp_cfg_regs.sv @@
// Configuration register file of the timer/counter.
// Depends on tcp_pkg for the register indexes and the configuration struct.
module tcp_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tcp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tcp_pkg::CFG_DATA_W-1:0]     cfg_data,
    output tcp_pkg::tcp_cfg_t                  cfg
);
    import tcp_pkg::*;

    tcp_cfg_t cfg_reg;
    tcp_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_WAVE_MODE:     cfg_next.wave_mode = wave_mode_t'(cfg_data[1:0]);
                CFG_CLOCK_SELECT:  cfg_next.clock_select = cfg_data[2:0];
                CFG_COMPARE_VALUE: cfg_next.compare_value = cfg_data[VALUE_W-1:0];
                CFG_INVERT_OUTPUT: cfg_next.invert_output = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{wave_mode: WAVE_NORMAL, clock_select: CS_STOP,
                         compare_value: '0, invert_output: 1'b0};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ sv/tcp_timer_step.sv @@
// Timer state (prescaler, counter, direction, waveform level) and the logic
// that advances it by one item. Depends on tcp_pkg.
module tcp_timer_step (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tcp_pkg::tcp_cfg_t             cfg,
    input  logic                          step,
    input  logic                          action,
    input  logic [tcp_pkg::VALUE_W-1:0]   load_value,
    output tcp_pkg::tcp_result_t          result
);
    import tcp_pkg::*;

    logic [PRESCALE_W-1:0]  prescale_count_reg, prescale_count_next;
    logic [COUNT_WIDTH-1:0] timer_count_reg, timer_count_next;
    logic                   counting_down_reg, counting_down_next;
    logic                   wave_level_reg, wave_level_next;

    logic [DIV_W-1:0]       div;
    logic [DIV_W-1:0]       presc_sum;
    logic                   tclk;
    logic [COUNT_WIDTH-1:0] cmp_ext;
    logic                   ovf;
    logic                   cmp;

    assign div = divisor_of(cfg.clock_select);
    assign presc_sum = DIV_W'(prescale_count_reg) + DIV_W'(1);
    assign tclk = (action == ACT_TICK) && (div != '0) && (presc_sum >= div);
    assign cmp_ext = COUNT_WIDTH'(cfg.compare_value);

    always_comb begin
        prescale_count_next = prescale_count_reg;
        timer_count_next = timer_count_reg;
        counting_down_next = counting_down_reg;
        wave_level_next = wave_level_reg;
        ovf = 1'b0;
        cmp = 1'b0;

        if (action == ACT_LOAD) begin
            timer_count_next = COUNT_WIDTH'(load_value);
            prescale_count_next = '0;
        end else if (div != '0) begin
            prescale_count_next = tclk ? '0 : presc_sum[PRESCALE_W-1:0];
        end

        if (tclk) begin
            if (cfg.wave_mode == WAVE_PHASE_PWM) begin
                if (!counting_down_reg) begin
                    if (timer_count_reg == TOP_COUNT) begin
                        counting_down_next = 1'b1;
                        timer_count_next = TOP_COUNT - COUNT_WIDTH'(1);
                    end else begin
                        timer_count_next = timer_count_reg + COUNT_WIDTH'(1);
                    end
                end else begin
                    if (timer_count_reg == '0) begin
                        counting_down_next = 1'b0;
                        timer_count_next = COUNT_WIDTH'(1);
                    end else begin
                        timer_count_next = timer_count_reg - COUNT_WIDTH'(1);
                    end
                end
                ovf = (timer_count_next == '0);
                cmp = (timer_count_next == cmp_ext);
                if (cmp) begin
                    if (cmp_ext == TOP_COUNT) begin
                        wave_level_next = 1'b1;
                    end else if (cmp_ext == '0) begin
                        wave_level_next = 1'b0;
                    end else begin
                        wave_level_next = counting_down_next;
                    end
                end
            end else begin
                cmp = (timer_count_reg == cmp_ext);
                ovf = (timer_count_reg == TOP_COUNT);
                // The counter wraps naturally from the top to zero.
                timer_count_next = timer_count_reg + COUNT_WIDTH'(1);
                if (cfg.wave_mode == WAVE_CTC && cmp) begin
                    timer_count_next = '0;
                end
                if (cfg.wave_mode == WAVE_FAST_PWM) begin
                    if (cmp) begin
                        wave_level_next = 1'b0;
                    end
                    if (timer_count_next == '0) begin
                        wave_level_next = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        result.count_now = timer_count_next[VALUE_W-1:0];
        result.overflow_event = ovf;
        result.compare_event = cmp;
        result.wave_pin = cfg.wave_mode[1] ? (wave_level_next ^ cfg.invert_output) : 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_count_reg <= '0;
            timer_count_reg <= '0;
            counting_down_reg <= 1'b0;
            wave_level_reg <= 1'b0;
        end else if (step) begin
            prescale_count_reg <= prescale_count_next;
            timer_count_reg <= timer_count_next;
            counting_down_reg <= counting_down_next;
            wave_level_reg <= wave_level_next;
        end
    end

endmodule
